[sv/rdf_pkg.sv]
// shared types, codes and defaults for the record deframer
package rdf_pkg;

  localparam int MAX_HEADER_BYTES_DEF = 8;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_HEADER_SIZE = 2'd0;
  localparam logic [1:0] REG_BIG_ENDIAN  = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  localparam logic [3:0]  HEADER_SIZE_RST = 4'd4;
  localparam logic        BIG_ENDIAN_RST  = 1'b0;
  localparam logic [30:0] MAX_LEN_RST     = 31'd65536;

  localparam logic [1:0] ST_PAYLOAD   = 2'd0;
  localparam logic [1:0] ST_BAD_LEN   = 2'd1;
  localparam logic [1:0] ST_EARLY_END = 2'd2;

  typedef struct packed {
    logic [3:0]  header_size;
    logic        big_endian;
    logic [30:0] max_record_len;
  } rdf_cfg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [30:0] len;
  } rdf_result_t;

endpackage

[sv/rdf_engine.sv]
// per-byte deframing state and step logic
module rdf_engine #(
  parameter int MAX_HEADER_BYTES = rdf_pkg::MAX_HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rdf_pkg::rdf_cfg_t   cfg,
  input  logic                take,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_data,
  output logic                emit,
  output rdf_pkg::rdf_result_t result
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_TRAILER = 2'd2;
  localparam logic [3:0] MAX_HS     = 4'(MAX_HEADER_BYTES);

  logic [1:0]  phase_r, phase_nxt;
  logic [30:0] count_r, count_nxt;
  logic [31:0] marker_r, marker_nxt;
  logic [30:0] cur_len_r, cur_len_nxt;

  logic [3:0]  hs;
  logic [1:0]  phase_e;
  logic [30:0] count_e;
  logic [31:0] marker_e;
  logic [30:0] count_inc;
  logic [31:0] marker_upd;
  logic        hs_done;
  logic        bad_len;

  always_comb begin
    if (cfg.header_size == 4'd0) begin
      hs = 4'd1;
    end else if (cfg.header_size > MAX_HS) begin
      hs = MAX_HS;
    end else begin
      hs = cfg.header_size;
    end
  end

  // unused phase code behaves as a fresh header wait
  assign phase_e  = (phase_r > PH_TRAILER) ? PH_HEADER : phase_r;
  assign count_e  = (phase_r > PH_TRAILER) ? 31'd0 : count_r;
  assign marker_e = (phase_r > PH_TRAILER) ? 32'd0 : marker_r;

  assign count_inc = count_e + 31'd1;
  assign hs_done   = count_inc >= {27'd0, hs};

  always_comb begin
    if (cfg.big_endian) begin
      marker_upd = {marker_e[23:0], in_byte};
    end else if (count_e < 31'd4) begin
      marker_upd = marker_e | ({24'd0, in_byte} << {count_e[1:0], 3'b000});
    end else begin
      marker_upd = marker_e;
    end
  end

  assign bad_len = (hs >= 4'd4 && marker_upd[31]) || (marker_upd == 32'd0) ||
                   (marker_upd > {1'b0, cfg.max_record_len});

  always_comb begin
    phase_nxt   = phase_e;
    count_nxt   = count_e;
    marker_nxt  = marker_e;
    cur_len_nxt = cur_len_r;
    emit        = 1'b0;
    result      = '0;
    if (in_end_of_data) begin
      emit          = 1'b1;
      result.status = rdf_pkg::ST_EARLY_END;
      result.len    = (phase_e == PH_HEADER) ? 31'd0 : cur_len_r;
      phase_nxt     = PH_HEADER;
      count_nxt     = 31'd0;
      marker_nxt    = 32'd0;
    end else begin
      case (phase_e)
        PH_PAYLOAD: begin
          emit        = 1'b1;
          result.data = in_byte;
          result.last = count_inc >= cur_len_r;
          result.len  = cur_len_r;
          if (count_inc >= cur_len_r) begin
            phase_nxt = PH_TRAILER;
            count_nxt = 31'd0;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_TRAILER: begin
          if (hs_done) begin
            phase_nxt  = PH_HEADER;
            count_nxt  = 31'd0;
            marker_nxt = 32'd0;
          end else begin
            count_nxt = count_inc;
          end
        end
        default: begin
          if (!hs_done) begin
            count_nxt  = count_inc;
            marker_nxt = marker_upd;
          end else if (bad_len) begin
            emit          = 1'b1;
            result.status = rdf_pkg::ST_BAD_LEN;
            phase_nxt     = PH_HEADER;
            count_nxt     = 31'd0;
            marker_nxt    = 32'd0;
          end else begin
            cur_len_nxt = marker_upd[30:0];
            phase_nxt   = PH_PAYLOAD;
            count_nxt   = 31'd0;
            marker_nxt  = marker_upd;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      count_r   <= 31'd0;
      marker_r  <= 32'd0;
      cur_len_r <= 31'd0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      marker_r  <= marker_nxt;
      cur_len_r <= cur_len_nxt;
    end
  end

endmodule

[sv/fortran_record_deframer_top.sv]
// top level of the unformatted sequential record deframer
//
// channel   direction  handshake                  payload
// in_       input      in_valid / in_ready        in_byte, in_end_of_data
// out_      output     out_valid / out_ready      out_byte, out_last_byte, out_status,
//                                                 out_record_len
// cfg_      apb slave  psel, penable, pwrite      paddr (4 bits), pwdata / prdata (32 bits)
//
// one item per cycle sustained while the result is drained; an item's result shows in the cycle after acceptance
// the step logic is one pass between the engine state and the output register
// in_ready stays high while the output register is empty or being drained this cycle
// a stalled result holds in the output register and blocks only the next item
// rst_n is synchronous; state returns to waiting for a header, registers to defaults
module fortran_record_deframer_top #(
  parameter int MAX_HEADER_BYTES = rdf_pkg::MAX_HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_end_of_data,
  // result stream
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last_byte,
  output logic [1:0]                    out_status,
  output logic [30:0]                   out_record_len,
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rdf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rdf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rdf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  rdf_pkg::rdf_cfg_t    cfg_r;
  rdf_pkg::rdf_result_t step_res;
  rdf_pkg::rdf_result_t res_r;
  logic                 out_valid_r;
  logic                 step_emit;
  logic                 take;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  // ---------------- configuration registers ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  // registers sit on word addresses; index is the word number
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_size    <= rdf_pkg::HEADER_SIZE_RST;
      cfg_r.big_endian     <= rdf_pkg::BIG_ENDIAN_RST;
      cfg_r.max_record_len <= rdf_pkg::MAX_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rdf_pkg::REG_HEADER_SIZE: cfg_r.header_size    <= cfg_pwdata[3:0];
        rdf_pkg::REG_BIG_ENDIAN:  cfg_r.big_endian     <= cfg_pwdata[0];
        rdf_pkg::REG_MAX_LEN:     cfg_r.max_record_len <= cfg_pwdata[30:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rdf_pkg::REG_HEADER_SIZE: cfg_prdata = {28'd0, cfg_r.header_size};
      rdf_pkg::REG_BIG_ENDIAN:  cfg_prdata = {31'd0, cfg_r.big_endian};
      rdf_pkg::REG_MAX_LEN:     cfg_prdata = {1'b0, cfg_r.max_record_len};
      default:                  cfg_prdata = '0;
    endcase
  end

  // ---------------- deframing engine ----------------
  // accept whenever the output register is free or empties this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  rdf_engine #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .take           (take),
    .in_byte        (in_byte),
    .in_end_of_data (in_end_of_data),
    .emit           (step_emit),
    .result         (step_res)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      // header and trailer bytes leave nothing behind, unless a header reads a bad length
      out_valid_r <= step_emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && step_emit) begin
      res_r <= step_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = res_r.data;
  assign out_last_byte  = res_r.last;
  assign out_status     = res_r.status;
  assign out_record_len = res_r.len;

endmodule

[sv/rdf_checker.sv]
// port-level checks for the record deframer, bound to the top level
module rdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last_byte,
  input logic [1:0]  out_status,
  input logic [30:0] out_record_len
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_byte, out_last_byte, out_status, out_record_len}))
    else $error("stalled result changed");

  // empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // status items carry no byte and no last flag
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rdf_pkg::ST_PAYLOAD |-> !out_last_byte && out_byte == 8'd0)
    else $error("status item carries payload");

  // bad length reports zero length
  a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rdf_pkg::ST_BAD_LEN |-> out_record_len == 31'd0)
    else $error("bad length item with nonzero length");

  // payload bytes belong to a record of nonzero length
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rdf_pkg::ST_PAYLOAD |-> out_record_len != 31'd0)
    else $error("payload byte with zero record length");

endmodule

bind fortran_record_deframer_top rdf_checker u_rdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_last_byte  (out_last_byte),
  .out_status     (out_status),
  .out_record_len (out_record_len)
);
